### design/lrsf_pkg.sv
package lrsf_pkg;

    localparam int RANGES    = 16;
    localparam int MaxCopies = 16;
    localparam int LineW     = 32;
    localparam int ByteW     = 8;
    localparam int SlotW     = 4;
    localparam int CountW    = 5;
    localparam int CopyW     = $clog2(MaxCopies);
    localparam int CfgIdxW   = 1;
    localparam int CfgDataW  = 5;

    localparam logic [ByteW-1:0] NewlineByte = 8'h0A;

    typedef enum logic
    {
        OpStream = 1'b0,
        OpRangeWrite = 1'b1
    } op_t;

    typedef enum logic [CfgIdxW-1:0]
    {
        RegRangeCount = 1'b0,
        RegNewlineMode = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0]
    {
        StIdle,
        StPre,
        StMatch,
        StEmit
    } state_t;

    typedef struct packed
    {
        logic table_wr;
        logic load_byte;
        logic advance;
        logic capture;
        logic pop;
    } cmd_t;

    typedef struct packed
    {
        logic is_newline;
        logic newline_mode;
        logic any_match;
        logic last;
    } stat_t;

endpackage

### design/lrsf_ifs.sv
interface lrsf_item_if
    import lrsf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              op;
    logic [ByteW-1:0]  data_byte;
    logic [SlotW-1:0]  range_slot;
    logic [LineW-1:0]  range_first;
    logic [LineW-1:0]  range_last;

    modport source (output valid, op, data_byte, range_slot, range_first, range_last,
                    input ready);
    modport sink (input valid, op, data_byte, range_slot, range_first, range_last,
                  output ready);
endinterface

interface lrsf_result_if
    import lrsf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ByteW-1:0]  out_byte;
    logic              last_copy;

    modport source (output valid, out_byte, last_copy, input ready);
    modport sink (input valid, out_byte, last_copy, output ready);
endinterface

### design/lrsf_ctrl.sv
module lrsf_ctrl
    import lrsf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    input  logic  item_op,
    output logic  item_ready,
    output logic  result_valid,
    input  logic  result_ready,
    input  stat_t stat,
    output cmd_t  cmd,
    output state_t state
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            StIdle:
            begin
                if (item_valid && (item_op == OpStream))
                begin
                    state_next = StPre;
                end
            end
            StPre:
            begin
                state_next = StMatch;
            end
            StMatch:
            begin
                state_next = StEmit;
            end
            StEmit:
            begin
                if (!stat.any_match || (result_ready && stat.last))
                begin
                    state_next = StIdle;
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        item_ready   = 1'b0;
        result_valid = 1'b0;
        unique case (state_reg)
            StIdle:
            begin
                item_ready    = 1'b1;
                cmd.table_wr  = item_valid && (item_op == OpRangeWrite);
                cmd.load_byte = item_valid && (item_op == OpStream);
            end
            StPre:
            begin
                cmd.advance = stat.is_newline && stat.newline_mode;
            end
            StMatch:
            begin
                cmd.capture = 1'b1;
            end
            StEmit:
            begin
                result_valid = stat.any_match;
                cmd.pop      = stat.any_match && result_ready;
                cmd.advance  = stat.is_newline && !stat.newline_mode &&
                               (!stat.any_match || (result_ready && stat.last));
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign state = state_reg;

endmodule

### design/lrsf_dpath.sv
module lrsf_dpath
    import lrsf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    input  logic [ByteW-1:0]    data_byte,
    input  logic [SlotW-1:0]    range_slot,
    input  logic [LineW-1:0]    range_first,
    input  logic [LineW-1:0]    range_last,
    output logic [ByteW-1:0]    out_byte,
    output logic                last_copy
);

    localparam logic [CopyW-1:0] LastCopyIdx = CopyW'(MaxCopies - 1);

    logic [CountW-1:0] count_reg;
    logic              mode_reg;
    logic [LineW-1:0]  line_reg;
    logic [ByteW-1:0]  byte_reg;
    logic              newline_reg;
    logic [RANGES-1:0] match_reg;
    logic [RANGES-1:0] match_next;
    logic [CopyW-1:0]  copies_reg;
    logic [LineW-1:0]  low_mem [RANGES];
    logic [LineW-1:0]  high_mem [RANGES];
    logic [RANGES-1:0] hit;
    logic [RANGES-1:0] rest;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegRangeCount:  count_reg <= cfg_data[CountW-1:0];
                RegNewlineMode: mode_reg  <= cfg_data[0];
                default:        count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.table_wr && (32'(range_slot) < RANGES))
        begin
            low_mem[range_slot]  <= range_first;
            high_mem[range_slot] <= range_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= LineW'(1);
        end
        else if (cmd.advance && (line_reg != '1))
        begin
            line_reg <= line_reg + LineW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
        begin
            byte_reg    <= data_byte;
            newline_reg <= (data_byte == NewlineByte);
        end
    end

    always_comb
    begin
        for (int i = 0; i < RANGES; i++)
        begin
            hit[i] = (32'(count_reg) > i) &&
                     (low_mem[i] <= line_reg) && (line_reg <= high_mem[i]);
        end
    end

    // clear the lowest set bit on each transfer
    assign rest = match_reg & (match_reg - RANGES'(1));

    always_comb
    begin
        match_next = match_reg;
        if (cmd.capture)
        begin
            match_next = hit;
        end
        else if (cmd.pop)
        begin
            match_next = stat.last ? '0 : rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg  <= '0;
            copies_reg <= '0;
        end
        else
        begin
            match_reg <= match_next;
            if (cmd.capture)
            begin
                copies_reg <= '0;
            end
            else if (cmd.pop)
            begin
                copies_reg <= copies_reg + CopyW'(1);
            end
        end
    end

    assign stat.is_newline   = newline_reg;
    assign stat.newline_mode = mode_reg;
    assign stat.any_match    = (match_reg != '0);
    assign stat.last         = (rest == '0) || (copies_reg == LastCopyIdx);

    assign out_byte  = byte_reg;
    assign last_copy = stat.last;

endmodule

### design/line_range_stream_filter.sv
// Line range filter: range-write items load entry range_slot of a 16-entry table of
// inclusive line ranges; stream items are copied to the output once per checked entry
// (entries 0 to range_count-1) whose range holds the current line, in table order, at
// most 16 copies, the last one flagged by last_copy. The line counter starts at 1,
// saturates, and steps on each 0x0A byte, before or after the match as the newline
// mode register says. A range write is written into the table from the idle state. For a
// stream byte the controller steps through the accept state, a pre-match state with
// the optional line advance, a parallel range compare, and one output transfer per
// copy, each held while the output is stalled; only one byte is in flight. The user
// must write the registers only while the block is idle; the block itself does not
// enforce this.
module line_range_stream_filter
    import lrsf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    lrsf_item_if.sink           item,
    lrsf_result_if.source       result,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    cmd_t   cmd;
    stat_t  stat;
    state_t state;

    lrsf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_op      (item.op),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .stat         (stat),
        .cmd          (cmd),
        .state        (state)
    );

    lrsf_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .data_byte   (item.data_byte),
        .range_slot  (item.range_slot),
        .range_first (item.range_first),
        .range_last  (item.range_last),
        .out_byte    (result.out_byte),
        .last_copy   (result.last_copy)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !item.ready)
        else $error("input taken while a copy is pending");

    a_stream_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && (item.op == OpStream)) |=> (state == StPre))
        else $error("stream byte transfer did not start matching");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && result.last_copy) |=> !result.valid)
        else $error("copies continue after last copy");

    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.table_wr, cmd.load_byte, cmd.capture, cmd.pop}))
        else $error("conflicting datapath commands");

endmodule
